>>> rtl/core/lpg_pkg.sv
// Shared types and constants of the line pixel generator.
package lpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 32;
  localparam logic [COLOR_BITS-1:0] LINE_COLOR_RESET = 32'hFF00_0000;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_a;
    logic [COORD_BITS-1:0] y_a;
    logic [COORD_BITS-1:0] x_b;
    logic [COORD_BITS-1:0] y_b;
    logic [COORD_BITS-1:0] step_index;
  } lpg_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  in_span;
    logic                  is_last;
  } lpg_out_t;

  // side data carried alongside the divider
  typedef struct packed {
    logic                  x_major;
    logic                  neg;
    logic [COORD_BITS-1:0] s_min;
    logic [COORD_BITS-1:0] major;
    logic                  in_span;
    logic                  is_last;
  } lpg_tag_t;

  localparam int TAG_BITS = $bits(lpg_tag_t);

endpackage

>>> rtl/core/lpg_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with side tag.
module lpg_divider #(
  parameter int WIDTH    = lpg_pkg::COORD_BITS,
  parameter int TAG_BITS = lpg_pkg::TAG_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2*WIDTH-1:0]    in_dividend,
  input  logic [WIDTH-1:0]      in_divisor,
  input  logic [TAG_BITS-1:0]   in_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WIDTH-1:0]      out_quotient,
  output logic [TAG_BITS-1:0]   out_tag
);

  // Dividend's upper half must already be below the divisor (quotient fits WIDTH).
  // Work word: upper half remainder, lower half dividend bits then quotient bits.
  logic [2*WIDTH-1:0]  w   [0:WIDTH];
  logic [WIDTH-1:0]    dvs [0:WIDTH];
  logic [TAG_BITS-1:0] tag [0:WIDTH];
  logic                vld [0:WIDTH];
  logic                rdy [0:WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
    if (rdy[0]) begin
      w[0]   <= in_dividend;
      dvs[0] <= in_divisor;
      tag[0] <= in_tag;
    end
  end

  genvar k;
  generate
    for (k = 0; k < WIDTH; k++) begin : g_step
      logic [WIDTH:0]     trial;
      logic [WIDTH:0]     diff;
      logic               ge;
      logic [WIDTH-1:0]   rem_next;
      logic [2*WIDTH-1:0] w_next;

      assign rdy[k]   = !vld[k] || rdy[k+1];
      assign trial    = {w[k][2*WIDTH-1:WIDTH], w[k][WIDTH-1]};
      assign ge       = trial >= {1'b0, dvs[k]};
      assign diff     = trial - {1'b0, dvs[k]};
      assign rem_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      assign w_next   = {rem_next, w[k][WIDTH-2:0], ge};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (rdy[k+1]) begin
          vld[k+1] <= vld[k];
        end
        if (rdy[k+1]) begin
          w[k+1]   <= w_next;
          dvs[k+1] <= dvs[k];
          tag[k+1] <= tag[k];
        end
      end
    end
  endgenerate

  assign rdy[WIDTH]   = !vld[WIDTH] || out_ready;
  assign in_ready     = rdy[0];
  assign out_valid    = vld[WIDTH];
  assign out_quotient = w[WIDTH][WIDTH-1:0];
  assign out_tag      = tag[WIDTH];

  generate
    for (k = 0; k < WIDTH; k++) begin : g_check
      a_rem_below: assert property (@(posedge clk) disable iff (rst)
        vld[k] |-> (w[k][2*WIDTH-1:WIDTH] < dvs[k]))
        else $error("divider remainder not below divisor");
    end
  endgenerate

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (dvs[0] != '0))
    else $error("divider fed a zero divisor");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("divider output valid straight after reset");

endmodule

>>> rtl/core/line_pixel_generator_core.sv
// Top level of the line pixel generator: one line pixel per item, fully pipelined.
//
// Each item gives two endpoints and a step index; the block returns the pixel at that
// step along the major axis (x when the x span is larger, otherwise y), with the minor
// coordinate start + delta*step/span rounded toward zero, plus in-span and last-pixel
// flags and the current line colour. One item is accepted per clock and one result
// leaves per clock while out_stall is low. The pipeline holds three setup/multiply
// stages, one input register and COORD_BITS one-bit stages of the restoring divider,
// and the output register. The divider depth sets the latency.
// The user must write the colour register only while the block is empty; the block does not enforce this.
module line_pixel_generator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lpg_pkg::lpg_in_t                  in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lpg_pkg::lpg_out_t                 out_item,
  input  logic                              cfg_write_en,
  input  logic [lpg_pkg::COLOR_BITS-1:0]    cfg_write_data
);

  localparam int C = lpg_pkg::COORD_BITS;

  // colour register
  logic [lpg_pkg::COLOR_BITS-1:0] line_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_color <= lpg_pkg::LINE_COLOR_RESET;
    end else if (cfg_write_en) begin
      line_color <= cfg_write_data;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: spans, major axis choice, coordinates sorted into major/minor
  // ---------------------------------------------------------------------
  logic         a_valid, a_ready;
  logic         a_x_major;
  logic [C-1:0] a_maj_a, a_maj_b, a_min_a, a_min_b, a_step;

  logic [C-1:0] dx, dy;
  logic         x_major_c;

  always_comb begin
    dx = (in_item.x_a > in_item.x_b) ? in_item.x_a - in_item.x_b : in_item.x_b - in_item.x_a;
    dy = (in_item.y_a > in_item.y_b) ? in_item.y_a - in_item.y_b : in_item.y_b - in_item.y_a;
    x_major_c = dx > dy;   // ties go to y
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready) begin
      a_x_major <= x_major_c;
      a_maj_a   <= x_major_c ? in_item.x_a : in_item.y_a;
      a_maj_b   <= x_major_c ? in_item.x_b : in_item.y_b;
      a_min_a   <= x_major_c ? in_item.y_a : in_item.x_a;
      a_min_b   <= x_major_c ? in_item.y_b : in_item.x_b;
      a_step    <= in_item.step_index;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: order endpoints, span, signed minor delta, flags, major coord
  // ---------------------------------------------------------------------
  logic         b_valid, b_ready;
  logic [C-1:0] b_mag, b_div, b_step;
  lpg_pkg::lpg_tag_t b_tag;

  logic         swap;
  logic [C-1:0] s_maj, e_maj, s_min, e_min, span;
  logic [C:0]   delta;

  always_comb begin
    swap  = a_maj_a > a_maj_b;   // equal major coords keep A as start
    s_maj = swap ? a_maj_b : a_maj_a;
    e_maj = swap ? a_maj_a : a_maj_b;
    s_min = swap ? a_min_b : a_min_a;
    e_min = swap ? a_min_a : a_min_b;
    span  = e_maj - s_maj;
    delta = {1'b0, e_min} - {1'b0, s_min};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready) begin
      // |delta| never exceeds the span, so it fits C bits
      b_mag         <= delta[C] ? C'(-delta) : delta[C-1:0];
      b_div         <= (span == '0) ? C'(1) : span;
      b_step        <= a_step;
      b_tag.x_major <= a_x_major;
      b_tag.neg     <= delta[C];
      b_tag.s_min   <= s_min;
      b_tag.major   <= s_maj + a_step;   // wraps past the edge
      b_tag.in_span <= a_step <= span;
      b_tag.is_last <= a_step == span;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: |delta| * step
  // ---------------------------------------------------------------------
  logic           c_valid, c_ready;
  logic [2*C-1:0] c_prod;
  logic [C-1:0]   c_div;
  lpg_pkg::lpg_tag_t c_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
    if (c_ready) begin
      c_prod <= b_mag * b_step;
      c_div  <= b_div;
      c_tag  <= b_tag;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: magnitude quotient; truncation toward zero comes from
  // dividing magnitudes and applying the sign afterwards
  // ---------------------------------------------------------------------
  logic                          div_in_ready, div_out_valid, div_out_ready;
  logic [C-1:0]                  div_quot;
  logic [lpg_pkg::TAG_BITS-1:0]  div_tag_bits;
  lpg_pkg::lpg_tag_t             d_tag;

  lpg_divider #(
    .WIDTH    (C),
    .TAG_BITS (lpg_pkg::TAG_BITS)
  ) u_divider (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (c_valid),
    .in_ready     (div_in_ready),
    .in_dividend  (c_prod),
    .in_divisor   (c_div),
    .in_tag       (c_tag),
    .out_valid    (div_out_valid),
    .out_ready    (div_out_ready),
    .out_quotient (div_quot),
    .out_tag      (div_tag_bits)
  );

  assign d_tag = lpg_pkg::lpg_tag_t'(div_tag_bits);

  // ---------------------------------------------------------------------
  // Output register: minor = start +/- quotient, map back to x/y
  // ---------------------------------------------------------------------
  logic [C-1:0] minor;

  always_comb begin
    minor = d_tag.neg ? d_tag.s_min - div_quot : d_tag.s_min + div_quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_out_ready) begin
      out_valid <= div_out_valid;
    end
    if (div_out_ready) begin
      out_item.pixel_x     <= d_tag.x_major ? d_tag.major : minor;
      out_item.pixel_y     <= d_tag.x_major ? minor : d_tag.major;
      out_item.pixel_color <= line_color;
      out_item.in_span     <= d_tag.in_span;
      out_item.is_last     <= d_tag.is_last;
    end
  end

  // a stage moves on when it is empty or the next stage moves
  assign div_out_ready = !out_valid || !out_stall;
  assign c_ready       = !c_valid || div_in_ready;
  assign b_ready       = !b_valid || c_ready;
  assign a_ready       = !a_valid || b_ready;
  assign in_stall      = !a_ready;

  a_last_in_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_last |-> out_item.in_span)
    else $error("last pixel flagged outside span");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> a_valid && b_valid && c_valid && out_valid)
    else $error("input stalled with an empty stage");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

>>> bench/lpg_pixel_checker.sv
`timescale 1ns / 100ps
// Pixel checker: watches both channels, predicts each pixel and compares it with the result.
module lpg_pixel_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  lpg_pkg::lpg_in_t               in_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  lpg_pkg::lpg_out_t              out_item,
  input  logic                           cfg_write_en,
  input  logic [lpg_pkg::COLOR_BITS-1:0] cfg_write_data,
  output int                             fail_count,
  output int                             outstanding
);

  logic [lpg_pkg::COLOR_BITS-1:0] line_colour;
  lpg_pkg::lpg_out_t              pending_pixels[$];

  // one pixel of the line, DDA style; division truncates toward zero
  function automatic lpg_pkg::lpg_out_t predict_pixel(
      input lpg_pkg::lpg_in_t it, input logic [lpg_pkg::COLOR_BITS-1:0] colour);
    int                xa, ya, xb, yb, st, dx, dy;
    int                s_maj, e_maj, s_min, e_min, swap, span, dvsr, major, minor;
    bit                x_major;
    lpg_pkg::lpg_out_t px;
    xa = int'(it.x_a);
    ya = int'(it.y_a);
    xb = int'(it.x_b);
    yb = int'(it.y_b);
    st = int'(it.step_index);
    dx = (xa > xb) ? xa - xb : xb - xa;
    dy = (ya > yb) ? ya - yb : yb - ya;
    x_major = dx > dy;
    if (x_major) begin
      s_maj = xa; e_maj = xb; s_min = ya; e_min = yb;
    end else begin
      s_maj = ya; e_maj = yb; s_min = xa; e_min = xb;
    end
    if (s_maj > e_maj) begin
      swap = s_maj; s_maj = e_maj; e_maj = swap;
      swap = s_min; s_min = e_min; e_min = swap;
    end
    span  = e_maj - s_maj;
    dvsr  = (span < 1) ? 1 : span;
    major = s_maj + st;
    minor = s_min + ((e_min - s_min) * st) / dvsr;
    px.pixel_x     = x_major ? major[lpg_pkg::COORD_BITS-1:0] : minor[lpg_pkg::COORD_BITS-1:0];
    px.pixel_y     = x_major ? minor[lpg_pkg::COORD_BITS-1:0] : major[lpg_pkg::COORD_BITS-1:0];
    px.pixel_color = colour;
    px.in_span     = st <= span;
    px.is_last     = st == span;
    return px;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lpg_pkg::lpg_out_t exp_px;
    if (rst) begin
      line_colour <= lpg_pkg::LINE_COLOR_RESET;
      pending_pixels.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write_en) line_colour <= cfg_write_data;
      if (in_valid && !in_stall) pending_pixels.push_back(predict_pixel(in_item, line_colour));
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected result: pixel_x %0h pixel_y %0h", out_item.pixel_x,
                 out_item.pixel_y);
          fail_count++;
        end else begin
          exp_px = pending_pixels.pop_front();
          check_field("pixel_x", 32'(exp_px.pixel_x), 32'(out_item.pixel_x));
          check_field("pixel_y", 32'(exp_px.pixel_y), 32'(out_item.pixel_y));
          check_field("pixel_color", exp_px.pixel_color, out_item.pixel_color);
          check_field("in_span", 32'(exp_px.in_span), 32'(out_item.in_span));
          check_field("is_last", 32'(exp_px.is_last), 32'(out_item.is_last));
        end
      end
      outstanding <= pending_pixels.size();
    end
  end

endmodule

>>> bench/tb_line_pixel_generator_core.sv
`timescale 1ns / 100ps
// Testbench top of the line pixel generator: clock, reset, stimulus, idling and verdict.
module tb_line_pixel_generator_core;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int          HOLD_CYCLES     = 300;  // long receiver hold-off, fills the pipe
  localparam int          DRAIN_CYCLES    = 30;
  localparam int          ITEMS_PER_PHASE = 350;
  localparam int          COORD_MAX       = (1 << lpg_pkg::COORD_BITS) - 1;

  logic                           clk            = 1'b0;
  logic                           rst            = 1'b1;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  lpg_pkg::lpg_in_t               in_item        = '0;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  lpg_pkg::lpg_out_t              out_item;
  logic                           cfg_write_en   = 1'b0;
  logic [lpg_pkg::COLOR_BITS-1:0] cfg_write_data = '0;

  wire [31:0]  fail_count;
  wire [31:0]  outstanding;
  int          idle_pct     = 0;
  int          stall_pct    = 0;
  bit          hold_pending = 1'b0;
  int unsigned cycle_count  = 0;

  line_pixel_generator_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  lpg_pixel_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: a hung pipe or a lost result ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL line_pixel_generator_core");
      $finish;
    end
  end

  // Receiver: random stall at the phase's rate; on request one long hold-off,
  // counted here, while the sender keeps offering items.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic lpg_pkg::lpg_in_t make_item(input int xa, input int ya, input int xb,
                                                 input int yb, input int st);
    lpg_pkg::lpg_in_t it;
    it.x_a        = xa[lpg_pkg::COORD_BITS-1:0];
    it.y_a        = ya[lpg_pkg::COORD_BITS-1:0];
    it.x_b        = xb[lpg_pkg::COORD_BITS-1:0];
    it.y_b        = yb[lpg_pkg::COORD_BITS-1:0];
    it.step_index = st[lpg_pkg::COORD_BITS-1:0];
    return it;
  endfunction

  // coordinates lean on the edges of the grid now and then
  function automatic int random_coord();
    case ($urandom_range(9))
      0:       return 0;
      1:       return COORD_MAX;
      default: return int'($urandom_range(COORD_MAX));
    endcase
  endfunction

  // Mostly steps that lie on the line (first, last, inside); some past the end.
  // A quarter of the lines are short, so the end of span is hit often.
  function automatic lpg_pkg::lpg_in_t random_line_item();
    int xa, ya, xb, yb, dx, dy, span, st;
    xa = random_coord();
    ya = random_coord();
    if ($urandom_range(3) == 0) begin
      xb = xa ^ int'($urandom_range(15));
      yb = ya ^ int'($urandom_range(15));
    end else begin
      xb = random_coord();
      yb = random_coord();
    end
    dx   = (xa > xb) ? xa - xb : xb - xa;
    dy   = (ya > yb) ? ya - yb : yb - ya;
    span = (dx > dy) ? dx : dy;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: st = int'($urandom_range(span));
      6:                st = span;
      7:                st = 0;
      8:                st = (span < COORD_MAX) ? int'($urandom_range(COORD_MAX, span + 1)) : 0;
      default:          st = int'($urandom_range(COORD_MAX));
    endcase
    return make_item(xa, ya, xb, yb, st);
  endfunction

  // present one item, with random gaps ahead of it at the phase's rate
  task automatic send_item(input lpg_pkg::lpg_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every predicted pixel has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // colour register is only touched with the pipe empty
  task automatic write_colour(input logic [lpg_pkg::COLOR_BITS-1:0] colour);
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= colour;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  initial begin : stimulus
    lpg_pkg::lpg_in_t               directed[$];
    logic [lpg_pkg::COLOR_BITS-1:0] colour;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset colour, no idling.
    directed.push_back(make_item(0, 0, 0, 0, 0));                  // zero span: first and last
    directed.push_back(make_item(0, 0, 0, 0, 1));                  // zero span, past the end
    directed.push_back(make_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX)); // wraps
    directed.push_back(make_item(0, 0, COORD_MAX, 0, 0));          // horizontal, first
    directed.push_back(make_item(0, 0, COORD_MAX, 0, COORD_MAX));  // horizontal, last
    directed.push_back(make_item(0, 0, COORD_MAX, 0, 2048));
    directed.push_back(make_item(COORD_MAX, 100, 0, 200, 1000));   // x major, endpoints swapped
    directed.push_back(make_item(300, 0, 310, COORD_MAX, COORD_MAX)); // y major, last
    directed.push_back(make_item(10, 10, 20, 20, 5));              // equal spans go to y
    directed.push_back(make_item(0, 0, COORD_MAX, COORD_MAX, COORD_MAX));
    directed.push_back(make_item(0, 4000, COORD_MAX, 0, 1234));    // falling minor, truncation
    directed.push_back(make_item(50, COORD_MAX, COORD_MAX, 0, 3)); // y major, swapped
    directed.push_back(make_item(COORD_MAX, 0, 0, COORD_MAX, COORD_MAX));
    directed.push_back(make_item(4000, 7, 4010, 9, COORD_MAX));    // far past the end, wraps
    directed.push_back(make_item(4000, 7, 4010, 9, 11));           // one past the end
    directed.push_back(make_item(4000, 7, 4010, 9, 9));            // one before the end
    directed.push_back(make_item(7, 7, 7, 3000, 3000));            // vertical
    directed.push_back(make_item(1, 2, 4094, 4093, 777));
    foreach (directed[i]) send_item(directed[i]);

    // Random phases: none / sender idle / receiver stalling / both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       colour = '0;
        1:       colour = '1;
        default: colour = $urandom();
      endcase
      write_colour(colour);
      idle_pct  = (phase == 1) ? 80 : (phase == 3) ? 13 : 0;
      stall_pct = (phase == 2) ? 80 : (phase == 3) ? 13 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (phase == 0 && i == 100) hold_pending = 1'b1;  // fill the pipe against a stall
        if (phase == 1 && i == ITEMS_PER_PHASE / 2) wait_drained();
        send_item(random_line_item());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS line_pixel_generator_core");
    end else begin
      $display("FAIL line_pixel_generator_core");
    end
    $finish;
  end

endmodule
